### rtl/core/sapm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapm_pkg
// Shared types and constants of the slice area piece measurer.
// ----------------------------------------------------------------------------
package sapm_pkg;

	localparam int PIXELS_PER_SENSOR = 10;
	localparam int PIECE_DEPTH       = 256;
	localparam int BATCH_DEPTH       = 256;

	localparam int SENSOR_COUNT = 11;
	localparam int SENSOR_W     = 10;
	localparam int PIX_W        = 7;
	localparam int PIX_MAX      = SENSOR_COUNT * PIXELS_PER_SENSOR;
	localparam int AREA_W       = PIX_W + 16;
	localparam int PIECE_AW     = (PIECE_DEPTH > 1) ? $clog2(PIECE_DEPTH) : 1;
	localparam int BATCH_LAST   = BATCH_DEPTH - 1;

	typedef logic [1:0] cfg_addr_t;

	typedef enum logic [1:0] {
		REG_END_GAP    = 2'd0,
		REG_PIXEL_AREA = 2'd1,
		REG_BATCH_SIZE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_PIECE = 1'b1
	} piece_state_t;

	typedef struct packed {
		logic [SENSOR_W-1:0] sensor_0;
		logic [SENSOR_W-1:0] sensor_1;
		logic [SENSOR_W-1:0] sensor_2;
		logic [SENSOR_W-1:0] sensor_3;
		logic [SENSOR_W-1:0] sensor_4;
		logic [SENSOR_W-1:0] sensor_5;
		logic [SENSOR_W-1:0] sensor_6;
		logic [SENSOR_W-1:0] sensor_7;
		logic [SENSOR_W-1:0] sensor_8;
		logic [SENSOR_W-1:0] sensor_9;
		logic [SENSOR_W-1:0] sensor_10;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0] slice_pixels;
		logic             measuring;
		logic             piece_done;
		logic [31:0]      piece_area;
		logic [15:0]      piece_number;
		logic [7:0]       batch_slot;
		logic [31:0]      batch_total;
		logic             batch_full;
	} result_t;

	typedef struct packed {
		logic [3:0]  end_gap;
		logic [15:0] pixel_area;
		logic [15:0] batch_size;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixels;
		logic [AREA_W-1:0] area;
	} slice_t;

endpackage

### rtl/core/sapm_slice.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapm_slice
// Input register, photoreceptor count and slice area product.
// ----------------------------------------------------------------------------
module sapm_slice (
	input  logic            clk,
	input  logic            load_s1,
	input  logic            load_s2,
	input  sapm_pkg::item_t item,
	input  sapm_pkg::cfg_t  cfg,
	output sapm_pkg::slice_t slice_s2
);
	import sapm_pkg::*;

	item_t            item_s1;
	logic [SENSOR_W-1:0] words [SENSOR_COUNT];
	logic [PIX_W-1:0] count;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		words[0]  = item_s1.sensor_0;
		words[1]  = item_s1.sensor_1;
		words[2]  = item_s1.sensor_2;
		words[3]  = item_s1.sensor_3;
		words[4]  = item_s1.sensor_4;
		words[5]  = item_s1.sensor_5;
		words[6]  = item_s1.sensor_6;
		words[7]  = item_s1.sensor_7;
		words[8]  = item_s1.sensor_8;
		words[9]  = item_s1.sensor_9;
		words[10] = item_s1.sensor_10;
	end

	always_comb begin
		count = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			for (int j = 0; j < PIXELS_PER_SENSOR; j++) begin
				count = count + PIX_W'(words[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			slice_s2.pixels <= count;
			slice_s2.area   <= AREA_W'(count) * AREA_W'(cfg.pixel_area);
		end
	end

endmodule

### rtl/core/sapm_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapm_tracker
// Piece state, area accumulation, piece store, batch sums and result register.
// The batch index only ever holds the first or the last slot, so those two
// slot sums are kept in registers cleared at reset.
// ----------------------------------------------------------------------------
module sapm_tracker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              update,
	input  sapm_pkg::slice_t  slice_s2,
	input  sapm_pkg::cfg_t    cfg,
	output sapm_pkg::result_t result_s3
);
	import sapm_pkg::*;

	piece_state_t state_q, state_d;
	logic [3:0]   empty_run_q, empty_run_d, run_inc;
	logic [31:0]  area_sum_q, area_sum_d;
	logic [15:0]  piece_count_q, piece_count_d;
	logic [7:0]   batch_index_q, batch_index_d;
	logic [31:0]  batch_first_q, batch_last_q, slot_sum, slot_new;
	logic         slot_is_last, nonempty, gap_hit, done, store_we;
	result_t      result_d;
	logic [31:0]  piece_store [PIECE_DEPTH];

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	assign nonempty     = slice_s2.pixels != '0;
	assign run_inc      = (empty_run_q == 4'hF) ? empty_run_q : empty_run_q + 4'd1;
	assign gap_hit      = run_inc >= cfg.end_gap;
	assign slot_is_last = batch_index_q == 8'(BATCH_LAST);
	assign slot_sum     = slot_is_last ? batch_last_q : batch_first_q;
	assign slot_new     = sat_add32(slot_sum, area_sum_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (nonempty) state_d = ST_PIECE;
			end
			ST_PIECE: begin
				if (!nonempty && gap_hit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		done          = (state_q == ST_PIECE) && !nonempty && gap_hit;
		empty_run_d   = empty_run_q;
		area_sum_d    = area_sum_q;
		piece_count_d = piece_count_q;
		batch_index_d = batch_index_q;
		store_we      = 1'b0;
		if (nonempty) begin
			area_sum_d  = sat_add32((state_q == ST_PIECE) ? area_sum_q : 32'd0,
				32'(slice_s2.area));
			empty_run_d = '0;
		end else if (state_q == ST_PIECE) begin
			empty_run_d = run_inc;
			if (done) begin
				empty_run_d = '0;
				store_we    = {1'b0, piece_count_q} < 17'(PIECE_DEPTH);
				if (piece_count_q != 16'hFFFF) piece_count_d = piece_count_q + 16'd1;
				if (piece_count_d >= cfg.batch_size) batch_index_d = 8'(BATCH_LAST);
			end
		end

		result_d              = '0;
		result_d.slice_pixels = slice_s2.pixels;
		result_d.measuring    = state_d == ST_PIECE;
		result_d.piece_done   = done;
		result_d.batch_full   = piece_count_d >= cfg.batch_size;
		if (done) begin
			result_d.piece_area   = area_sum_q;
			result_d.piece_number = piece_count_q;
			result_d.batch_slot   = batch_index_q;
			result_d.batch_total  = slot_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			empty_run_q   <= '0;
			area_sum_q    <= '0;
			piece_count_q <= '0;
			batch_index_q <= '0;
			batch_first_q <= '0;
			batch_last_q  <= '0;
		end else if (update) begin
			state_q       <= state_d;
			empty_run_q   <= empty_run_d;
			area_sum_q    <= area_sum_d;
			piece_count_q <= piece_count_d;
			batch_index_q <= batch_index_d;
			if (done) begin
				if (slot_is_last) batch_last_q <= slot_new;
				else batch_first_q <= slot_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			result_s3 <= result_d;
		end
		if (update && store_we) begin
			piece_store[piece_count_q[PIECE_AW-1:0]] <= area_sum_q;
		end
	end

endmodule

### rtl/core/slice_area_piece_measurer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slice_area_piece_measurer_core
// An accepted item beat passes the input, slice and result registers to its result beat.
// Throughput: one item per cycle when the output is not stalled, set by the three-stage pipeline
// (input register, count and multiply, piece update and result register).
// Reset: asynchronous; clears pipeline valids, piece state, counters,
// batch sums, and loads default register values. No clearing pass.
// ----------------------------------------------------------------------------
module slice_area_piece_measurer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  sapm_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output sapm_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  sapm_pkg::cfg_addr_t cfg_index,
	input  logic [15:0]         cfg_data
);
	import sapm_pkg::*;

	cfg_t   cfg_q;
	slice_t slice_s2;
	logic   v1_q, v2_q, v3_q;
	logic   rdy1, rdy2, rdy3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_gap    <= 4'd3;
			cfg_q.pixel_area <= 16'd50;
			cfg_q.batch_size <= 16'd100;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_END_GAP:    cfg_q.end_gap    <= cfg_data[3:0];
				REG_PIXEL_AREA: cfg_q.pixel_area <= cfg_data;
				REG_BATCH_SIZE: cfg_q.batch_size <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rdy3       = !v3_q || !result_stall;
	assign rdy2       = !v2_q || rdy3;
	assign rdy1       = !v1_q || rdy2;
	assign item_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= item_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
		end
	end

	sapm_slice u_slice (
		.clk      (clk),
		.load_s1  (item_valid && rdy1),
		.load_s2  (v1_q && rdy2),
		.item     (item),
		.cfg      (cfg_q),
		.slice_s2 (slice_s2)
	);

	sapm_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (v2_q && rdy3),
		.slice_s2  (slice_s2),
		.cfg       (cfg_q),
		.result_s3 (result)
	);

	assign result_valid = v3_q;

	a_done_not_measuring: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.piece_done && result.measuring))
		else $error("piece ended but still measuring");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (v1_q && v2_q && v3_q))
		else $error("item stalled with a free stage");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.piece_done) |->
		(result.batch_slot == 8'd0 || result.batch_slot == 8'(BATCH_LAST)))
		else $error("batch slot outside first or last");

	a_pixel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.slice_pixels <= PIX_W'(PIX_MAX)))
		else $error("slice pixel count out of range");

endmodule

### dv/slice_area_piece_measurer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slice_area_piece_measurer_core_tb
// Drives encoder slices through the measurer under random bursts and output
// stalls, mirrors the piece, batch and register state in a local model, and
// compares every result beat field by field. It covers default and extreme
// register settings and long solid pieces at the largest pixel area.
// ----------------------------------------------------------------------------
module slice_area_piece_measurer_core_tb;

	import sapm_pkg::*;

	localparam int        QUIET_LIMIT = 2000;
	localparam int        HOLD_CYCLES = 300;
	localparam int        SLICE_W     = SENSOR_COUNT * SENSOR_W;
	localparam cfg_addr_t REG_SPARE   = 2'd3;

	typedef enum int {RX_OPEN, RX_COIN, RX_RARE, RX_PERIODIC} rx_mode_t;
	typedef enum int {SL_NOISE, SL_SPARSE, SL_SOLID, SL_MIXED} slice_style_t;

	typedef struct packed {
		item_t   slice;
		logic    typed;
		result_t want;
	} dir_row_t;

	localparam dir_row_t DIRECTED [19] = '{
		'{slice: '0, typed: 1'b1, want: '0},
		'{slice: '1, typed: 1'b1,
			want: '{slice_pixels: 7'd110, measuring: 1'b1, default: '0}},
		'{slice: '{sensor_0: 10'h001, default: '0}, typed: 1'b1,
			want: '{slice_pixels: 7'd1, measuring: 1'b1, default: '0}},
		'{slice: '{sensor_10: 10'h200, default: '0}, typed: 1'b1,
			want: '{slice_pixels: 7'd1, measuring: 1'b1, default: '0}},
		'{slice: '0, typed: 1'b1, want: '{measuring: 1'b1, default: '0}},
		'{slice: '0, typed: 1'b1, want: '{measuring: 1'b1, default: '0}},
		'{slice: '0, typed: 1'b1,
			want: '{piece_done: 1'b1, piece_area: 32'd5600, batch_total: 32'd5600,
				default: '0}},
		'{slice: '{sensor_5: 10'h155, default: '0}, typed: 1'b0, want: '0},
		'{slice: '{sensor_6: 10'h2AA, default: '0}, typed: 1'b0, want: '0},
		'{slice: '0, typed: 1'b0, want: '0},
		'{slice: '{sensor_3: 10'h3FF, default: '0}, typed: 1'b0, want: '0},
		'{slice: '0, typed: 1'b0, want: '0},
		'{slice: '0, typed: 1'b0, want: '0},
		'{slice: '0, typed: 1'b0, want: '0},
		'{slice: '{default: 10'h155}, typed: 1'b0, want: '0},
		'{slice: '{default: 10'h2AA}, typed: 1'b0, want: '0},
		'{slice: '0, typed: 1'b0, want: '0},
		'{slice: '0, typed: 1'b0, want: '0},
		'{slice: '0, typed: 1'b0, want: '0}
	};

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_addr_t   cfg_index;
	logic [15:0] cfg_data;

	logic [3:0]  gap_reg;
	logic [15:0] pix_area_reg;
	logic [15:0] batch_reg;

	piece_state_t piece_st;
	logic [3:0]   empty_run;
	logic [31:0]  area_acc;
	logic [15:0]  piece_count;
	logic [7:0]   batch_index;
	logic [31:0]  batch_sums [BATCH_DEPTH];

	result_t pending_results [$];
	int      errors;
	int      slices_sent;
	int      results_seen;
	int      pieces_done;
	int      settings_used;
	int      burst_left;
	bit      idle_on;
	int      hold_req;
	int      quiet;
	logic [31:0] peak_area;

	slice_area_piece_measurer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic measure_slice(input item_t s, output result_t r);
		logic [SLICE_W-1:0]  v;
		logic [SENSOR_W-1:0] mask;
		int unsigned         pixels;
		v = s;
		mask = SENSOR_W'((1 << PIXELS_PER_SENSOR) - 1);
		pixels = 0;
		r = '0;
		for (int i = 0; i < SENSOR_COUNT; i++)
			pixels += $countones(v[i*SENSOR_W +: SENSOR_W] & mask);
		if (pixels != 0) begin
			if (piece_st == ST_IDLE) begin
				piece_st = ST_PIECE;
				area_acc = '0;
			end
			area_acc = sat_add(area_acc, pixels * pix_area_reg);
			empty_run = '0;
		end else if (piece_st == ST_PIECE) begin
			if (empty_run < 4'd15)
				empty_run++;
			if (empty_run >= gap_reg) begin
				piece_st = ST_IDLE;
				empty_run = '0;
				r.piece_done = 1'b1;
				r.piece_area = area_acc;
				r.piece_number = piece_count;
				r.batch_slot = batch_index;
				batch_sums[batch_index] = sat_add(batch_sums[batch_index], area_acc);
				r.batch_total = batch_sums[batch_index];
				if (piece_count != 16'hFFFF)
					piece_count++;
				if (piece_count >= batch_reg)
					batch_index = 8'(BATCH_LAST);
				pieces_done++;
				if (area_acc > peak_area)
					peak_area = area_acc;
			end
		end
		r.slice_pixels = PIX_W'(pixels);
		r.measuring = (piece_st == ST_PIECE);
		r.batch_full = (piece_count >= batch_reg);
	endtask

	function automatic item_t rand_slice();
		logic [SLICE_W-1:0] v;
		slice_style_t       style;
		style = slice_style_t'($urandom_range(0, 3));
		v = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			case (style)
				SL_NOISE: v[i*SENSOR_W +: SENSOR_W] = SENSOR_W'($urandom);
				SL_SOLID: v[i*SENSOR_W +: SENSOR_W] = '1;
				SL_MIXED: begin
					case ($urandom_range(0, 2))
						0:       v[i*SENSOR_W +: SENSOR_W] = '0;
						1:       v[i*SENSOR_W +: SENSOR_W] = '1;
						default: v[i*SENSOR_W +: SENSOR_W] = SENSOR_W'($urandom);
					endcase
				end
				default: ;
			endcase
		end
		if (v == '0)
			v[$urandom_range(0, SLICE_W - 1)] = 1'b1;
		return item_t'(v);
	endfunction

	task automatic drive_slice(input item_t s, input logic typed = 1'b0,
			input result_t want = '0);
		result_t pred;
		int      gap;
		if (idle_on && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				item_valid = 1'b0;
			end
			burst_left = $urandom_range(1, 30);
		end
		@(negedge clk);
		item_valid = 1'b1;
		item = s;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		measure_slice(s, pred);
		pending_results.push_back(typed ? want : pred);
		slices_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_addr_t idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		case (idx)
			REG_END_GAP:    gap_reg = data[3:0];
			REG_PIXEL_AREA: pix_area_reg = data;
			REG_BATCH_SIZE: batch_reg = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_regs(input logic [3:0] gap, input logic [15:0] area,
			input logic [15:0] batch);
		wait_drained();
		write_reg(REG_END_GAP, {12'($urandom), gap});
		write_reg(REG_PIXEL_AREA, area);
		write_reg(REG_BATCH_SIZE, batch);
		settings_used++;
	endtask

	task automatic random_phase(input int n);
		int start;
		int eff_gap;
		int len;
		start = slices_sent;
		while (slices_sent - start < n) begin
			eff_gap = (gap_reg == 0) ? 1 : gap_reg;
			len = $urandom_range(1, 10);
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 4))
						drive_slice($urandom_range(0, 1) ? item_t'('0) : rand_slice());
				end
				1: begin
					repeat (len) drive_slice(rand_slice());
					repeat ($urandom_range(0, eff_gap - 1)) drive_slice('0);
				end
				default: begin
					repeat (len) begin
						drive_slice(rand_slice());
						if (eff_gap > 1 && $urandom_range(0, 5) == 0)
							repeat ($urandom_range(1, eff_gap - 1)) drive_slice('0);
					end
					repeat (eff_gap) drive_slice('0);
				end
			endcase
		end
	endtask

	task automatic compare_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing pending");
				errors++;
			end else begin
				want = pending_results.pop_front();
				compare_field("slice_pixels", want.slice_pixels, result.slice_pixels);
				compare_field("measuring", want.measuring, result.measuring);
				compare_field("piece_done", want.piece_done, result.piece_done);
				compare_field("piece_area", want.piece_area, result.piece_area);
				compare_field("piece_number", want.piece_number, result.piece_number);
				compare_field("batch_slot", want.batch_slot, result.batch_slot);
				compare_field("batch_total", want.batch_total, result.batch_total);
				compare_field("batch_full", want.batch_full, result.batch_full);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)
				|| (cfg_valid && cfg_ready === 1'b1))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       hold_seen;
		int       tick;
		mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		hold_seen = 0;
		tick = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_stall = 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					RX_OPEN:  result_stall = 1'b0;
					RX_COIN:  result_stall = 1'($urandom_range(0, 1));
					RX_RARE:  result_stall = ($urandom_range(0, 7) == 0);
					default:  result_stall = (tick % 8 >= 5);
				endcase
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_END_GAP;
		cfg_data = '0;
		gap_reg = 4'd3;
		pix_area_reg = 16'd50;
		batch_reg = 16'd100;
		piece_st = ST_IDLE;
		empty_run = '0;
		area_acc = '0;
		piece_count = '0;
		batch_index = '0;
		foreach (batch_sums[i])
			batch_sums[i] = '0;
		errors = 0;
		slices_sent = 0;
		results_seen = 0;
		pieces_done = 0;
		settings_used = 1;
		burst_left = 0;
		idle_on = 1'b1;
		hold_req = 0;
		quiet = 0;
		peak_area = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			drive_slice(DIRECTED[i].slice, DIRECTED[i].typed, DIRECTED[i].want);
		random_phase(30);
		wait_drained();
		random_phase(30);

		set_regs(4'd1, 16'd1, 16'd1);
		random_phase(40);

		set_regs(4'd15, 16'hFFFF, 16'hFFFF);
		random_phase(30);
		hold_req++;
		random_phase(30);

		set_regs(4'd0, 16'd0, 16'd0);
		random_phase(40);

		wait_drained();
		write_reg(REG_SPARE, 16'($urandom));
		random_phase(15);

		repeat (2) begin
			set_regs(4'($urandom_range(1, 15)), 16'($urandom), 16'($urandom_range(0, 400)));
			random_phase(35);
		end

		set_regs(4'd2, 16'hFFFF, 16'd50);
		repeat (2) begin
			repeat (25) drive_slice('1);
			repeat (2) drive_slice('0);
		end

		wait_drained();
		repeat (4) @(posedge clk);
		$display("Checked %0d result beats for %0d slices and %0d pieces over %0d settings.",
			results_seen, slices_sent, pieces_done, settings_used);
		$display("Piece count ended at %0d; largest piece area %0d.", piece_count, peak_area);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
